### design/trmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmg_pkg: shared types and constants of the trimmed-mean battery gauge
// Holds the controller command bundle, the result field widths, the level
// thresholds and the level update function.
// ----------------------------------------------------------------------------
package trmg_pkg;

	localparam int IN_W    = 13;
	localparam int AVG_W   = 13;
	localparam int LEVEL_W = 7;
	localparam int CMP_W   = 16;

	localparam logic [CMP_W-1:0] TH_FULL_LO  = 16'd4100;
	localparam logic [CMP_W-1:0] TH_HIGH_LO  = 16'd3700;
	localparam logic [CMP_W-1:0] TH_HIGH_HI  = 16'd4000;
	localparam logic [CMP_W-1:0] TH_MID_LO   = 16'd3300;
	localparam logic [CMP_W-1:0] TH_MID_HI   = 16'd3600;
	localparam logic [CMP_W-1:0] TH_LOW_LO   = 16'd2900;
	localparam logic [CMP_W-1:0] TH_LOW_HI   = 16'd3200;
	localparam logic [CMP_W-1:0] TH_EMPTY_HI = 16'd2600;

	localparam logic [LEVEL_W-1:0] LEVEL_100 = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_75  = 7'd75;
	localparam logic [LEVEL_W-1:0] LEVEL_50  = 7'd50;
	localparam logic [LEVEL_W-1:0] LEVEL_25  = 7'd25;
	localparam logic [LEVEL_W-1:0] LEVEL_0   = 7'd0;

	typedef struct packed {
		logic write;
		logic sort_step;
		logic sort_odd;
		logic acc_clear;
		logic shift;
		logic acc_add;
		logic div_step;
		logic commit;
		logic out_load;
		logic out_updated;
	} cmd_t;

	// Inside a dead band or exactly on a threshold the held level stays.
	function automatic logic [LEVEL_W-1:0] level_next(input logic [CMP_W-1:0] v,
			input logic [LEVEL_W-1:0] held);
		logic [LEVEL_W-1:0] lvl;
		lvl = held;
		if (v > TH_FULL_LO) begin
			lvl = LEVEL_100;
		end else if (v > TH_HIGH_LO && v < TH_HIGH_HI) begin
			lvl = LEVEL_75;
		end else if (v > TH_MID_LO && v < TH_MID_HI) begin
			lvl = LEVEL_50;
		end else if (v > TH_LOW_LO && v < TH_LOW_HI) begin
			lvl = LEVEL_25;
		end else if (v < TH_EMPTY_HI) begin
			lvl = LEVEL_0;
		end
		return lvl;
	endfunction

endpackage

### design/trimmed_mean_battery_gauge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_battery_gauge_unit: trimmed-mean battery voltage gauge
// Collects voltage samples, and on the sample after a full window reports
// the mean of the sorted window without its lowest and highest entries,
// together with a coarse charge level.
//
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  sample_mv
// result    out        result_valid / result_ready  average_mv, level_percent,
//                                                   average_updated
//
// A sample that is stored gives its result in the next cycle.
// A sample that closes a full window takes WINDOW_SIZE sort passes,
// WINDOW_SIZE minus the trim count summing shifts, one scaling of the sum
// by the reciprocal of the kept count, then a commit and a load of the result.
// One transaction is in work at a time; a held result stalls new samples
// only when the output register is full and not being taken.
// Reset clears the fill count, the average and the level.
// ----------------------------------------------------------------------------
module trimmed_mean_battery_gauge_unit #(
	parameter int WINDOW_SIZE = 10,
	parameter int TRIM_COUNT  = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  logic [trmg_pkg::IN_W-1:0]        sample_mv,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [trmg_pkg::AVG_W-1:0]       average_mv,
	output logic [trmg_pkg::LEVEL_W-1:0]     level_percent,
	output logic                             average_updated
);
	import trmg_pkg::*;

	cmd_t                           cmd;
	logic [$clog2(WINDOW_SIZE)-1:0] wr_idx;
	logic [IN_W-1:0]                smoothed;
	logic [LEVEL_W-1:0]             level;
	logic                           out_free;
	logic                           result_valid_q;
	logic [AVG_W-1:0]               average_mv_q;
	logic [LEVEL_W-1:0]             level_percent_q;
	logic                           average_updated_q;

	assign out_free = !result_valid_q || result_ready;

	trmg_ctrl #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.TRIM_COUNT  (TRIM_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.out_free     (out_free),
		.cmd          (cmd),
		.wr_idx       (wr_idx)
	);

	trmg_datapath #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.TRIM_COUNT  (TRIM_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_idx    (wr_idx),
		.sample_mv (sample_mv),
		.smoothed  (smoothed),
		.level     (level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			average_mv_q      <= AVG_W'(smoothed);
			level_percent_q   <= level;
			average_updated_q <= cmd.out_updated;
		end
	end

	assign result_valid    = result_valid_q;
	assign average_mv      = average_mv_q;
	assign level_percent   = level_percent_q;
	assign average_updated = average_updated_q;

endmodule

### design/trmg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmg_ctrl: sequencing controller of the trimmed-mean battery gauge
// Tracks the fill count and steps the datapath through sorting, trimmed
// summing and the reciprocal scaling of each new average.
// ----------------------------------------------------------------------------
module trmg_ctrl #(
	parameter int WINDOW_SIZE = 10,
	parameter int TRIM_COUNT  = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  logic                             out_free,
	output trmg_pkg::cmd_t                   cmd,
	output logic [$clog2(WINDOW_SIZE)-1:0]   wr_idx
);
	import trmg_pkg::*;

	localparam int EFF_TRIM = (2 * TRIM_COUNT < WINDOW_SIZE) ? TRIM_COUNT
			: (WINDOW_SIZE - 1) / 2;
	localparam int KEEP   = WINDOW_SIZE - 2 * EFF_TRIM;
	localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
	localparam int IDX_W  = $clog2(WINDOW_SIZE);
	localparam int CNT_W  = $clog2(WINDOW_SIZE);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SORT   = 6'b000010,
		S_SUM    = 6'b000100,
		S_DIV    = 6'b001000,
		S_COMMIT = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t             state_q;
	logic [FILL_W-1:0]  fill_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               accept;
	logic               full;

	assign sample_ready = (state_q == S_IDLE) && out_free;
	assign accept       = sample_valid && sample_ready;
	assign full         = (fill_q == FILL_W'(WINDOW_SIZE));
	assign wr_idx       = fill_q[IDX_W-1:0];

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.write     = !full;
					cmd.out_load  = !full;
					cmd.acc_clear = full;
				end
			end
			S_SORT: begin
				cmd.sort_step = 1'b1;
				cmd.sort_odd  = cnt_q[0];
			end
			S_SUM: begin
				cmd.shift   = 1'b1;
				cmd.acc_add = (cnt_q >= CNT_W'(EFF_TRIM));
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
			end
			S_OUT: begin
				cmd.out_load    = 1'b1;
				cmd.out_updated = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (full) begin
							fill_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_SORT;
						end else begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				S_SORT: begin
					if (cnt_q == CNT_W'(WINDOW_SIZE - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SUM;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SUM: begin
					if (cnt_q == CNT_W'(EFF_TRIM + KEEP - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DIV: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/trmg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmg_datapath: sample store, sorter, accumulator and divider
// The store sorts itself by odd-even transposition passes, then shifts its
// middle entries into an accumulator that is divided by the kept count
// through one multiplication by its scaled reciprocal.
// ----------------------------------------------------------------------------
module trmg_datapath #(
	parameter int WINDOW_SIZE = 10,
	parameter int TRIM_COUNT  = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  trmg_pkg::cmd_t                   cmd,
	input  logic [$clog2(WINDOW_SIZE)-1:0]   wr_idx,
	input  logic [trmg_pkg::IN_W-1:0]        sample_mv,
	output logic [trmg_pkg::IN_W-1:0]        smoothed,
	output logic [trmg_pkg::LEVEL_W-1:0]     level
);
	import trmg_pkg::*;

	localparam int EFF_TRIM = (2 * TRIM_COUNT < WINDOW_SIZE) ? TRIM_COUNT
			: (WINDOW_SIZE - 1) / 2;
	localparam int KEEP    = WINDOW_SIZE - 2 * EFF_TRIM;
	localparam int SUM_W   = IN_W + $clog2(KEEP + 1);
	localparam int DIV_SH  = SUM_W + $clog2(KEEP);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << DIV_SH) + KEEP - 1) / KEEP);

	logic [IN_W-1:0]        store_q [WINDOW_SIZE];
	logic [IN_W-1:0]        store_d [WINDOW_SIZE];
	logic [IN_W-1:0]        sample_masked;
	logic [SUM_W-1:0]       acc_q;
	logic [PROD_W-1:0]      prod;
	logic [IN_W-1:0]        smoothed_q;
	logic [LEVEL_W-1:0]     level_q;

	assign sample_masked = sample_mv;

	always_comb begin
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			store_d[i] = store_q[i];
		end
		if (cmd.write) begin
			store_d[wr_idx] = sample_masked;
		end else if (cmd.sort_step) begin
			for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
				if ((i % 2) == int'(cmd.sort_odd) && store_q[i] > store_q[i + 1]) begin
					store_d[i]     = store_q[i + 1];
					store_d[i + 1] = store_q[i];
				end
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
				store_d[i] = store_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			store_q[i] <= store_d[i];
		end
	end

	assign prod = PROD_W'(acc_q) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + SUM_W'(store_q[0]);
		end else if (cmd.div_step) begin
			acc_q <= SUM_W'(prod >> DIV_SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			level_q    <= LEVEL_0;
		end else if (cmd.commit) begin
			smoothed_q <= acc_q[IN_W-1:0];
			level_q    <= level_next(CMP_W'(acc_q[IN_W-1:0]), level_q);
		end
	end

	assign smoothed = smoothed_q;
	assign level    = level_q;

endmodule

### dv/tb_trimmed_mean_battery_gauge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_mean_battery_gauge_unit: self-checking bench for the battery gauge
// Feeds voltage samples through the sample channel and checks every result
// transaction against a local model of the window, the trimmed mean and the
// held charge level. A short table of directed windows comes first, then
// random windows aimed at the level thresholds, the dead bands and the full
// sample range, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_battery_gauge_unit;
	import trmg_pkg::*;

	localparam int WIN          = 10;
	localparam int TRIM         = 3;
	localparam int KEEP         = WIN - 2 * TRIM;
	localparam int DIR_ROWS     = 22;
	localparam int RAND_WINDOWS = 55;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [AVG_W-1:0]   avg;
		logic [LEVEL_W-1:0] lvl;
		logic               upd;
	} gauge_result_t;

	typedef struct packed {
		logic [IN_W-1:0] mv;
		logic            typed;
		gauge_result_t   res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	logic [IN_W-1:0]      sample_mv = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [AVG_W-1:0]     average_mv;
	logic [LEVEL_W-1:0]   level_percent;
	logic                 average_updated;

	logic [IN_W-1:0]      window_store [WIN];
	int                   window_fill = 0;
	logic [AVG_W-1:0]     mean_mv = '0;
	logic [LEVEL_W-1:0]   level_held = LEVEL_0;

	gauge_result_t        expected_gauge_q [$];
	dir_row_t             dir_tab [DIR_ROWS];
	int                   mismatch_count = 0;
	int                   cycle_count = 0;
	int                   rx_hold = 0;
	logic                 quiet_phase = 1'b0;
	int                   th_list [8] = '{TH_EMPTY_HI, TH_LOW_LO, TH_LOW_HI, TH_MID_LO,
		TH_MID_HI, TH_HIGH_LO, TH_HIGH_HI, TH_FULL_LO};

	trimmed_mean_battery_gauge_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.sample_mv       (sample_mv),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.average_mv      (average_mv),
		.level_percent   (level_percent),
		.average_updated (average_updated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic gauge_result_t predict_gauge(input logic [IN_W-1:0] mv);
		gauge_result_t r;
		logic [IN_W-1:0] v;
		logic [IN_W+4:0] sum;
		int i;
		int j;
		r.upd = 1'b0;
		if (window_fill >= WIN) begin
			for (i = 1; i < WIN; i++) begin
				v = window_store[i];
				j = i - 1;
				while (j >= 0 && window_store[j] > v) begin
					window_store[j + 1] = window_store[j];
					j--;
				end
				window_store[j + 1] = v;
			end
			sum = '0;
			for (i = TRIM; i < TRIM + KEEP; i++) begin
				sum += window_store[i];
			end
			mean_mv = AVG_W'(sum / KEEP);
			window_fill = 0;
			r.upd = 1'b1;
		end else begin
			window_store[window_fill] = mv;
			window_fill++;
		end
		if (mean_mv > TH_FULL_LO) begin
			level_held = LEVEL_100;
		end else if (mean_mv > TH_HIGH_LO && mean_mv < TH_HIGH_HI) begin
			level_held = LEVEL_75;
		end else if (mean_mv > TH_MID_LO && mean_mv < TH_MID_HI) begin
			level_held = LEVEL_50;
		end else if (mean_mv > TH_LOW_LO && mean_mv < TH_LOW_HI) begin
			level_held = LEVEL_25;
		end else if (mean_mv < TH_EMPTY_HI) begin
			level_held = LEVEL_0;
		end
		r.avg = mean_mv;
		r.lvl = level_held;
		return r;
	endfunction

	task automatic send_sample(input logic [IN_W-1:0] mv, input logic typed,
			input gauge_result_t typed_res);
		gauge_result_t pred;
		int gap;
		sample_valid <= 1'b1;
		sample_mv <= mv;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		pred = predict_gauge(mv);
		expected_gauge_q.push_back(typed ? typed_res : pred);
		gap = quiet_phase ? 0 : pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (quiet_phase) begin
				result_ready <= 1'b1;
				rx_hold <= 0;
			end else if (rx_hold != 0) begin
				result_ready <= 1'b0;
				rx_hold <= rx_hold - 1;
			end else begin
				result_ready <= 1'b1;
				rx_hold <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		gauge_result_t exp_res;
		if (arst_n && result_valid && result_ready) begin
			if (expected_gauge_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatch_count++;
			end else begin
				exp_res = expected_gauge_q.pop_front();
				if (average_mv !== exp_res.avg) begin
					$error("average_mv: expected %0d, actual %0d", exp_res.avg, average_mv);
					mismatch_count++;
				end
				if (level_percent !== exp_res.lvl) begin
					$error("level_percent: expected %0d, actual %0d", exp_res.lvl,
						level_percent);
					mismatch_count++;
				end
				if (average_updated !== exp_res.upd) begin
					$error("average_updated: expected %0d, actual %0d", exp_res.upd,
						average_updated);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int row;
		int w;
		int k;
		int mode;
		int tgt;
		int jit;
		int val;
		// A full window of maximum samples, then one of alternating extremes.
		dir_tab[0]  = {13'd8191, 1'b1, 13'd0, LEVEL_0, 1'b0};
		dir_tab[1]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[2]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[3]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[4]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[5]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[6]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[7]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[8]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[9]  = {13'd8191, 1'b0, 21'd0};
		dir_tab[10] = {13'd0,    1'b1, 13'd8191, LEVEL_100, 1'b1};
		dir_tab[11] = {13'd0,    1'b0, 21'd0};
		dir_tab[12] = {13'd8191, 1'b0, 21'd0};
		dir_tab[13] = {13'd0,    1'b0, 21'd0};
		dir_tab[14] = {13'd8191, 1'b0, 21'd0};
		dir_tab[15] = {13'd0,    1'b0, 21'd0};
		dir_tab[16] = {13'd8191, 1'b0, 21'd0};
		dir_tab[17] = {13'd0,    1'b0, 21'd0};
		dir_tab[18] = {13'd8191, 1'b0, 21'd0};
		dir_tab[19] = {13'd0,    1'b0, 21'd0};
		dir_tab[20] = {13'd8191, 1'b0, 21'd0};
		dir_tab[21] = {13'd4100, 1'b1, 13'd4095, LEVEL_100, 1'b1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_ROWS; row++) begin
			send_sample(dir_tab[row].mv, dir_tab[row].typed, dir_tab[row].res);
		end

		for (w = 0; w < RAND_WINDOWS; w++) begin
			quiet_phase <= ($urandom_range(0, 4) == 0);
			mode = $urandom_range(0, 9);
			tgt = th_list[$urandom_range(0, 7)] + $urandom_range(0, 6) - 3;
			jit = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			for (k = 0; k <= WIN; k++) begin
				if (mode < 4) begin
					val = tgt + $urandom_range(0, 2 * jit) - jit;
				end else if (mode < 7) begin
					val = $urandom_range(2400, 4300);
				end else if (mode < 9) begin
					val = $urandom_range(0, 8191);
				end else begin
					val = $urandom_range(0, 1) ? 8191 - $urandom_range(0, 3) :
						$urandom_range(0, 3);
				end
				send_sample(IN_W'(val), 1'b0, '0);
			end
		end

		sample_valid <= 1'b0;
		quiet_phase <= 1'b0;
		while (expected_gauge_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
